### hw/rtl/mm_pkg.sv
package mm_pkg;

	localparam int ELEM_W     = 16;
	localparam int PRODUCT_W  = 36;
	localparam int IDX_W      = 3;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int LOAD_W     = 8;
	localparam int OUT_DATA_W = 48;
	localparam int FLUSH_CYCLES = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	typedef struct packed {
		logic shift;
		logic mul;
		logic acc;
		logic clr;
		logic drain;
	} cell_ctl_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} out_info_t;

endpackage

### hw/rtl/mm_cell.sv
module mm_cell #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                                 clk,
	input  mm_pkg::cell_ctl_t                    ctl,
	input  logic signed [DATA_WIDTH-1:0]         a_val,
	input  logic signed [DATA_WIDTH-1:0]         b_in,
	output logic signed [DATA_WIDTH-1:0]         b_out,
	input  logic signed [mm_pkg::PRODUCT_W-1:0]  acc_in,
	output logic signed [mm_pkg::PRODUCT_W-1:0]  acc_out
);

	logic signed [DATA_WIDTH-1:0]        b_q;
	logic signed [2*DATA_WIDTH-1:0]      prod_s3;
	logic signed [mm_pkg::PRODUCT_W-1:0] prod_ext;
	logic signed [mm_pkg::PRODUCT_W-1:0] acc_q;

	assign prod_ext = mm_pkg::PRODUCT_W'(prod_s3);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			b_q <= b_in;
		end
		if (ctl.mul) begin
			prod_s3 <= a_val * b_q;
		end
		if (ctl.drain) begin
			acc_q <= acc_in;
		end else if (ctl.acc) begin
			acc_q <= ctl.clr ? prod_ext : acc_q + prod_ext;
		end
	end

	assign b_out   = b_q;
	assign acc_out = acc_q;

endmodule

### hw/rtl/mm_ctrl.sv
module mm_ctrl #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             in_first,
	input  logic [mm_pkg::ELEM_W-1:0]        in_element,
	input  logic                             out_free,
	output mm_pkg::cell_ctl_t                ctl,
	output logic signed [DATA_WIDTH-1:0]     a_val,
	output logic signed [DATA_WIDTH-1:0]     b_val,
	output mm_pkg::out_info_t                info
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_DIM);
	localparam int LW    = mm_pkg::LOAD_W;
	localparam int CW    = mm_pkg::CFG_W;
	localparam logic [CW-1:0] DIM_MAX = CW'(MAX_DIM);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] v);
		logic [CW-1:0] d;
		d = v;
		if (v == '0) begin
			d = CW'(1);
		end else if (v > DIM_MAX) begin
			d = DIM_MAX;
		end
		return d;
	endfunction

	logic [CW-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [CW-1:0] nr, ni, nc;
	logic [IW-1:0] nr_m1, ni_m1, nc_m1;
	logic [LW-1:0] a_size, total;

	logic [1:0]    state_q;
	logic [LW-1:0] load_q;
	logic [IW-1:0] r_q, j_q, c_q, cout_q;
	logic [AW-1:0] a_base_q, b_base_q;
	logic [1:0]    wait_q;

	logic [DATA_WIDTH-1:0] a_mem [DEPTH];
	logic [DATA_WIDTH-1:0] b_mem [DEPTH];

	logic                          accept;
	logic [LW-1:0]                 lc_eff, lc_next, b_slot;
	logic                          in_a, wr_a, wr_b, done;
	logic signed [DATA_WIDTH-1:0]  wdata;
	logic                          issue;
	logic [AW-1:0]                 a_addr, b_addr;

	logic                          v_s1, lastc_s1, firstj_s1;
	logic signed [DATA_WIDTH-1:0]  a_rd_s1, b_rd_s1;
	logic                          mul_s2, clr_s2;
	logic signed [DATA_WIDTH-1:0]  a_s2;
	logic                          acc_s3, clr_s3;

	assign nr     = clamp_dim(rows_a_q);
	assign ni     = clamp_dim(inner_dim_q);
	assign nc     = clamp_dim(cols_b_q);
	assign nr_m1  = IW'(nr - CW'(1));
	assign ni_m1  = IW'(ni - CW'(1));
	assign nc_m1  = IW'(nc - CW'(1));
	assign a_size = LW'(nr) * LW'(ni);
	assign total  = a_size + LW'(ni) * LW'(nc);

	assign in_ready = (state_q == ST_LOAD);
	assign accept   = in_valid && in_ready;
	assign lc_eff   = in_first ? '0 : load_q;
	assign b_slot   = lc_eff - a_size;
	assign in_a     = lc_eff < a_size;
	assign wr_a     = accept && in_a;
	assign wr_b     = accept && !in_a && (b_slot < LW'(DEPTH));
	assign lc_next  = lc_eff + LW'(1);
	assign done     = lc_next >= total;
	assign wdata    = DATA_WIDTH'(in_element);

	assign issue  = (state_q == ST_RUN);
	assign a_addr = a_base_q + AW'(j_q);
	assign b_addr = b_base_q + AW'(c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= mm_pkg::DIM_RESET;
			inner_dim_q <= mm_pkg::DIM_RESET;
			cols_b_q    <= mm_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mm_pkg::REG_ROWS_A:    rows_a_q    <= cfg_data;
				mm_pkg::REG_INNER_DIM: inner_dim_q <= cfg_data;
				mm_pkg::REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			a_mem[lc_eff[AW-1:0]] <= wdata;
		end
		if (wr_b) begin
			b_mem[b_slot[AW-1:0]] <= wdata;
		end
		a_rd_s1 <= a_mem[a_addr];
		b_rd_s1 <= b_mem[b_addr];
		a_s2    <= a_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			load_q    <= '0;
			r_q       <= '0;
			j_q       <= '0;
			c_q       <= '0;
			cout_q    <= '0;
			a_base_q  <= '0;
			b_base_q  <= '0;
			wait_q    <= '0;
			v_s1      <= 1'b0;
			lastc_s1  <= 1'b0;
			firstj_s1 <= 1'b0;
			mul_s2    <= 1'b0;
			clr_s2    <= 1'b0;
			acc_s3    <= 1'b0;
			clr_s3    <= 1'b0;
		end else begin
			v_s1      <= issue;
			lastc_s1  <= issue && (c_q == '0);
			firstj_s1 <= (j_q == '0);
			mul_s2    <= lastc_s1;
			clr_s2    <= firstj_s1;
			acc_s3    <= mul_s2;
			clr_s3    <= clr_s2;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						load_q <= done ? '0 : lc_next;
						if (done) begin
							state_q  <= ST_RUN;
							r_q      <= '0;
							j_q      <= '0;
							c_q      <= nc_m1;
							a_base_q <= '0;
							b_base_q <= '0;
						end
					end
				end
				ST_RUN: begin
					if (c_q == '0) begin
						if (j_q == ni_m1) begin
							state_q <= ST_WAIT;
							wait_q  <= '0;
						end else begin
							j_q      <= j_q + IW'(1);
							c_q      <= nc_m1;
							b_base_q <= b_base_q + AW'(nc);
						end
					end else begin
						c_q <= c_q - IW'(1);
					end
				end
				ST_WAIT: begin
					if (wait_q == 2'(mm_pkg::FLUSH_CYCLES)) begin
						state_q <= ST_DRAIN;
						cout_q  <= '0;
					end else begin
						wait_q <= wait_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						if (cout_q == nc_m1) begin
							if (r_q == nr_m1) begin
								state_q <= ST_LOAD;
							end else begin
								state_q  <= ST_RUN;
								r_q      <= r_q + IW'(1);
								a_base_q <= a_base_q + AW'(ni);
								j_q      <= '0;
								c_q      <= nc_m1;
								b_base_q <= '0;
							end
						end else begin
							cout_q <= cout_q + IW'(1);
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign ctl.shift = v_s1;
	assign ctl.mul   = mul_s2;
	assign ctl.acc   = acc_s3;
	assign ctl.clr   = clr_s3;
	assign ctl.drain = (state_q == ST_DRAIN) && out_free;

	assign a_val = a_s2;
	assign b_val = b_rd_s1;

	assign info.row  = mm_pkg::IDX_W'(r_q);
	assign info.col  = mm_pkg::IDX_W'(cout_q);
	assign info.last = (r_q == nr_m1) && (cout_q == nc_m1);

	a_shift_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.drain && (ctl.shift || ctl.acc)))
		else $error("chain shift or accumulate during drain");

	a_mul_acc: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mul |=> ctl.acc)
		else $error("product not accumulated");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(ctl.shift || ctl.mul || ctl.acc))
		else $error("pipeline busy while loading");

	a_last_load: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.drain && info.last) |=> in_ready)
		else $error("no return to load after last result");

endmodule

### hw/rtl/matrix_multiply.sv
// Dense signed integer matrix multiply, C = A x B.
// Input stream: s_tdata carries one element, s_tuser marks the first element
// of a new problem. Elements come A row-major, then B row-major; the sizes are
// set through the cfg port (index 0 rows_a, 1 inner_dim, 2 cols_b); the user
// must write them only while idle, which the block does not enforce. Output
// stream: one transfer per element of C in row-major order; m_tlast marks the
// final one. Sums are exact at 36 bits. Loading takes one element per cycle
// while s_tvalid is high. After the last B element the block stops taking
// input and works row by row: per row of C it streams every B row from the
// B memory, one value per cycle, into the cell chain (one cell per column),
// then flushes the pipeline, then shifts the column sums out. The single B
// read port sets the pace of the compute phase.
// Reset clears control and load position; stored elements are undefined
// until written. A stall on m_tready holds the output register and, during
// the shift-out, the chain; input is taken again once the final result is in
// the output register.
module matrix_multiply #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mm_pkg::ELEM_W-1:0]         s_tdata,  // [15:0] element
	input  logic                              s_tuser,  // [0] first
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mm_pkg::OUT_DATA_W-1:0]     m_tdata,  // [35:0] product, [38:36] row_index,
	                                                    // [41:39] col_index, [47:42] zero
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]          cfg_data
);

	localparam int PW  = mm_pkg::PRODUCT_W;
	localparam int PAD = mm_pkg::OUT_DATA_W - PW - 2 * mm_pkg::IDX_W;

	mm_pkg::cell_ctl_t            ctl;
	mm_pkg::out_info_t            info;
	logic signed [DATA_WIDTH-1:0] a_val, b_val;
	logic                         out_free;
	logic                         m_valid_q;
	logic [mm_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                         out_last_q;

	logic signed [DATA_WIDTH-1:0] b_link   [MAX_DIM+1];
	logic signed [PW-1:0]         acc_link [MAX_DIM+1];

	assign out_free = !m_valid_q || m_tready;

	mm_ctrl #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_first   (s_tuser),
		.in_element (s_tdata),
		.out_free   (out_free),
		.ctl        (ctl),
		.a_val      (a_val),
		.b_val      (b_val),
		.info       (info)
	);

	assign b_link[0]         = b_val;
	assign acc_link[MAX_DIM] = '0;

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		mm_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.a_val   (a_val),
			.b_in    (b_link[k]),
			.b_out   (b_link[k+1]),
			.acc_in  (acc_link[k+1]),
			.acc_out (acc_link[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.drain) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			out_data_q <= {{PAD{1'b0}}, info.col, info.row, acc_link[0]};
			out_last_q <= info.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

### tb/sv/tb_matrix_multiply.sv
`timescale 1ns / 1ps

module tb_matrix_multiply;

	localparam int MAX_DIM       = 8;
	localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
	localparam int SETTLE_CYCLES = mm_pkg::FLUSH_CYCLES + 8;

	typedef struct {
		logic [mm_pkg::PRODUCT_W-1:0] product;
		logic [mm_pkg::IDX_W-1:0]     row;
		logic [mm_pkg::IDX_W-1:0]     col;
		logic                         last;
	} mm_result_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [mm_pkg::ELEM_W-1:0]     s_tdata   = '0;
	logic                          s_tuser   = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [mm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                          m_tlast;
	logic                          cfg_we    = 1'b0;
	logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mm_pkg::CFG_W-1:0]      cfg_data  = '0;

	int tx_idle_pct  = 30;
	int rx_idle_pct  = 56;
	int rx_hold_req  = 0;
	int rx_hold_left = 0;
	int mismatch_count = 0;

	logic signed [mm_pkg::ELEM_W-1:0] a_mem [STORE_DEPTH];
	logic signed [mm_pkg::ELEM_W-1:0] b_mem [STORE_DEPTH];
	logic [mm_pkg::LOAD_W-1:0]        load_pos  = '0;
	logic [mm_pkg::CFG_W-1:0]         cfg_rows  = mm_pkg::DIM_RESET;
	logic [mm_pkg::CFG_W-1:0]         cfg_inner = mm_pkg::DIM_RESET;
	logic [mm_pkg::CFG_W-1:0]         cfg_cols  = mm_pkg::DIM_RESET;
	mm_result_t                       pending_products [$];

	matrix_multiply u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned dim_of(logic [mm_pkg::CFG_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > MAX_DIM) return MAX_DIM;
		return raw;
	endfunction

	function automatic logic [mm_pkg::ELEM_W-1:0] pick_element();
		logic [mm_pkg::ELEM_W-1:0] v;
		case ($urandom_range(7))
			0: v = {1'b1, {(mm_pkg::ELEM_W-1){1'b0}}};
			1: v = {1'b0, {(mm_pkg::ELEM_W-1){1'b1}}};
			2: v = '0;
			3: v = '1;
			default: v = mm_pkg::ELEM_W'($urandom);
		endcase
		return v;
	endfunction

	// store one element; on completing B, queue every product element in row-major order
	task automatic load_and_multiply(logic first, logic [mm_pkg::ELEM_W-1:0] elem);
		int unsigned nr, ni, nc, a_size, total, slot;
		longint acc;
		mm_result_t res;
		nr = dim_of(cfg_rows);
		ni = dim_of(cfg_inner);
		nc = dim_of(cfg_cols);
		a_size = nr * ni;
		total = a_size + ni * nc;
		if (first) load_pos = '0;
		slot = load_pos;
		if (slot < a_size) a_mem[slot] = elem;
		else if (slot - a_size < STORE_DEPTH) b_mem[slot - a_size] = elem;
		load_pos = load_pos + 1'b1;
		if (load_pos < total) return;
		load_pos = '0;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				acc = 0;
				for (int j = 0; j < ni; j++)
					acc += longint'(a_mem[r * ni + j]) * longint'(b_mem[j * nc + c]);
				res.product = acc[mm_pkg::PRODUCT_W-1:0];
				res.row = r[mm_pkg::IDX_W-1:0];
				res.col = c[mm_pkg::IDX_W-1:0];
				res.last = (r == nr - 1) && (c == nc - 1);
				pending_products.push_back(res);
			end
		end
	endtask

	task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// the transfer happens at the next rising edge; values are stable here
	always @(negedge clk) begin : product_check
		mm_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_products.size() == 0) begin
				report_mismatch("unexpected transfer", '0, m_tdata);
			end else begin
				want = pending_products.pop_front();
				if (m_tdata[mm_pkg::PRODUCT_W-1:0] !== want.product)
					report_mismatch("product", want.product,
						m_tdata[mm_pkg::PRODUCT_W-1:0]);
				if (m_tdata[mm_pkg::PRODUCT_W +: mm_pkg::IDX_W] !== want.row)
					report_mismatch("row_index", want.row,
						m_tdata[mm_pkg::PRODUCT_W +: mm_pkg::IDX_W]);
				if (m_tdata[mm_pkg::PRODUCT_W + mm_pkg::IDX_W +: mm_pkg::IDX_W] !== want.col)
					report_mismatch("col_index", want.col,
						m_tdata[mm_pkg::PRODUCT_W + mm_pkg::IDX_W +: mm_pkg::IDX_W]);
				if (m_tlast !== want.last)
					report_mismatch("last", want.last, m_tlast);
			end
		end
	end

	task automatic send_element(logic first, logic [mm_pkg::ELEM_W-1:0] elem);
		logic taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= first;
		s_tdata  <= elem;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		load_and_multiply(first, elem);
	endtask

	task automatic send_problem(int count, logic first);
		for (int k = 0; k < count; k++)
			send_element((k == 0) ? first : 1'b0, pick_element());
	endtask

	// drop valid, wait for all products, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_products.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [mm_pkg::CFG_IDX_W-1:0] idx, logic [mm_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			mm_pkg::REG_ROWS_A:    cfg_rows  = val;
			mm_pkg::REG_INNER_DIM: cfg_inner = val;
			mm_pkg::REG_COLS_B:    cfg_cols  = val;
			default: ;
		endcase
	endtask

	task automatic set_dims(logic [mm_pkg::CFG_W-1:0] r, logic [mm_pkg::CFG_W-1:0] i,
			logic [mm_pkg::CFG_W-1:0] c);
		drain();
		write_cfg(mm_pkg::REG_ROWS_A, r);
		write_cfg(mm_pkg::REG_INNER_DIM, i);
		write_cfg(mm_pkg::REG_COLS_B, c);
	endtask

	task automatic test_unit_dims();
		set_dims(4'd0, 4'd0, 4'd0);
		send_element(1'b1, 16'h8000);
		send_element(1'b0, 16'h8000);
		drain();
	endtask

	task automatic test_restart_on_first();
		set_dims(4'd1, 4'd1, 4'd1);
		send_element(1'b1, 16'h7FFF);
		send_element(1'b1, 16'h8000);
		send_element(1'b0, 16'h7FFF);
		drain();
	endtask

	task automatic test_resize_mid_load();
		set_dims(4'd2, 4'd2, 4'd2);
		send_problem(5, 1'b1);
		drain();
		write_cfg(mm_pkg::REG_COLS_B, 4'd1);
		send_element(1'b0, pick_element());
		drain();
	endtask

	task automatic test_wide_outer();
		set_dims(4'd15, 4'd1, 4'd15);
		send_problem(16, 1'b1);
		drain();
	endtask

	task automatic test_output_backpressure();
		set_dims(4'd2, 4'd2, 4'd2);
		rx_hold_req = 300;
		repeat (4) send_problem(8, 1'b1);
		drain();
		send_problem(8, 1'b1);
		drain();
	endtask

	task automatic test_random_problems(int budget);
		int sent, pick, n_total, n_send, hi;
		logic restart_next;
		logic first;
		logic [mm_pkg::CFG_W-1:0] r, i, c;
		sent = 0;
		restart_next = 1'b1;
		while (sent < budget) begin
			if ($urandom_range(99) < 30) begin
				pick = $urandom_range(99);
				hi = $urandom_range(1) ? 8 : 4;
				if (pick < 8) begin
					r = mm_pkg::CFG_W'($urandom_range(8, 15));
					i = mm_pkg::CFG_W'($urandom_range(8, 15));
					c = mm_pkg::CFG_W'($urandom_range(8, 15));
				end else if (pick < 18) begin
					r = mm_pkg::CFG_W'($urandom_range(0, 2));
					i = mm_pkg::CFG_W'($urandom_range(0, 2));
					c = mm_pkg::CFG_W'($urandom_range(0, 2));
				end else begin
					r = mm_pkg::CFG_W'($urandom_range(1, hi));
					i = mm_pkg::CFG_W'($urandom_range(1, hi));
					c = mm_pkg::CFG_W'($urandom_range(1, hi));
				end
				set_dims(r, i, c);
				restart_next = 1'b1;
			end
			n_total = dim_of(cfg_rows) * dim_of(cfg_inner) + dim_of(cfg_inner) * dim_of(cfg_cols);
			first = restart_next ? 1'b1 : 1'($urandom_range(1));
			if ($urandom_range(9) == 0) begin
				n_send = $urandom_range(1, n_total - 1);
				restart_next = 1'b1;
			end else begin
				n_send = n_total;
				restart_next = 1'b0;
			end
			send_problem(n_send, first);
			sent += n_send;
		end
		drain();
	endtask

	// shrink the sizes far below the loaded count: the next element lies past B and is dropped
	task automatic test_overrun_drop();
		set_dims(4'd8, 4'd8, 4'd8);
		send_problem(100, 1'b1);
		drain();
		write_cfg(mm_pkg::REG_ROWS_A, 4'd1);
		write_cfg(mm_pkg::REG_INNER_DIM, 4'd1);
		write_cfg(mm_pkg::REG_COLS_B, 4'd1);
		send_element(1'b0, pick_element());
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unit_dims();
		test_restart_on_first();
		test_resize_mid_load();
		test_wide_outer();
		test_output_backpressure();
		test_random_problems(40);
		tx_idle_pct = 56;
		rx_idle_pct = 30;
		test_random_problems(40);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_problems(40);
		test_overrun_drop();
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
hw/rtl/mm_pkg.sv
hw/rtl/mm_cell.sv
hw/rtl/mm_ctrl.sv
hw/rtl/matrix_multiply.sv
tb/sv/tb_matrix_multiply.sv
